// ===== hw/rtl/pce_pkg.sv =====
// Shared types, constants and puncturing helpers for the punctured convolutional encoder.
package pce_pkg;

  localparam int DATA_BITS  = 8;
  localparam int TAIL_BITS  = 6;
  localparam int MAX_PAIRS  = DATA_BITS + TAIL_BITS;
  localparam int HIST_W     = MAX_PAIRS + TAIL_BITS;
  localparam int CHUNK_W    = 2 * MAX_PAIRS;
  localparam int CNT_W      = 5;
  localparam int VRAW_W     = 40;
  localparam int ACC_W      = 40;
  localparam int FILL_W     = 6;
  localparam int MAX_FILL   = 35;
  localparam int K          = 7;

  localparam logic [K-1:0] GEN_A = 7'o133;
  localparam logic [K-1:0] GEN_B = 7'o171;

  typedef enum logic [1:0] {
    RATE_1_2 = 2'd0,
    RATE_2_3 = 2'd1,
    RATE_3_4 = 2'd2,
    RATE_5_6 = 2'd3
  } rate_t;

  // One encoded input byte: kept bits MSB first, their count, frame end mark
  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [CNT_W-1:0]   count;
    logic               last;
  } pce_item_t;

  typedef struct packed {
    logic [TAIL_BITS-1:0] shreg;
    logic [2:0]           phase;
  } pce_front_status_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              pend_last;
  } pce_back_status_t;

  // Puncture period in coded bit pairs
  function automatic logic [2:0] pce_period(input rate_t rate);
    logic [2:0] per;
    unique case (rate)
      RATE_1_2: per = 3'd1;
      RATE_2_3: per = 3'd2;
      RATE_3_4: per = 3'd3;
      RATE_5_6: per = 3'd5;
      default:  per = 3'd1;
    endcase
    return per;
  endfunction

  // Phase after eight data bits, starting from a normalized phase
  function automatic logic [2:0] pce_next_phase(input rate_t rate, input logic [2:0] ph);
    logic [2:0] nph;
    nph = 3'd0;
    unique case (rate)
      RATE_1_2: nph = 3'd0;
      RATE_2_3: nph = ph;
      RATE_3_4: begin
        unique case (ph)
          3'd0:    nph = 3'd2;
          3'd1:    nph = 3'd0;
          default: nph = 3'd1;
        endcase
      end
      RATE_5_6: begin
        unique case (ph)
          3'd0:    nph = 3'd3;
          3'd1:    nph = 3'd4;
          3'd2:    nph = 3'd0;
          3'd3:    nph = 3'd1;
          default: nph = 3'd2;
        endcase
      end
      default: nph = 3'd0;
    endcase
    return nph;
  endfunction

  // Number of kept bits for one byte, with or without the tail
  function automatic logic [CNT_W-1:0] pce_kept_count(input rate_t rate, input logic [2:0] ph,
                                                      input logic last);
    logic [CNT_W-1:0] cnt;
    unique case (rate)
      RATE_1_2: cnt = last ? 5'd28 : 5'd16;
      RATE_2_3: cnt = last ? 5'd21 : 5'd12;
      RATE_3_4: cnt = (last ? 5'd16 : 5'd8) + ((ph == 3'd1) ? 5'd2 : 5'd3);
      RATE_5_6: begin
        if (last) begin
          cnt = (ph == 3'd1) ? 5'd16 : 5'd17;
        end else begin
          cnt = (ph == 3'd1 || ph == 3'd2) ? 5'd9 : 5'd10;
        end
      end
      default:  cnt = 5'd0;
    endcase
    return cnt;
  endfunction

  // Compact a phase-zero aligned raw stream (A at even, B at odd index) by the keep pattern
  function automatic logic [VRAW_W-1:0] pce_compact(input rate_t rate,
                                                    input logic [VRAW_W-1:0] raw);
    logic [VRAW_W-1:0] c;
    c = '0;
    unique case (rate)
      RATE_1_2: c = raw;
      RATE_2_3: begin
        for (int g = 0; g < 10; g++) begin
          c[3*g]   = raw[4*g];
          c[3*g+1] = raw[4*g+1];
          c[3*g+2] = raw[4*g+2];
        end
      end
      RATE_3_4: begin
        for (int g = 0; g < 6; g++) begin
          c[4*g]   = raw[6*g];
          c[4*g+1] = raw[6*g+1];
          c[4*g+2] = raw[6*g+2];
          c[4*g+3] = raw[6*g+5];
        end
      end
      RATE_5_6: begin
        for (int g = 0; g < 4; g++) begin
          c[6*g]   = raw[10*g];
          c[6*g+1] = raw[10*g+1];
          c[6*g+2] = raw[10*g+2];
          c[6*g+3] = raw[10*g+5];
          c[6*g+4] = raw[10*g+6];
          c[6*g+5] = raw[10*g+9];
        end
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/pce_front.sv =====
// Front end: accepts data bytes, runs the K=7 encoder and punctures the coded pairs.
module pce_front (
  input  logic                  clk,
  input  logic                  rst,
  input  pce_pkg::rate_t        rate,
  input  logic                  data_valid,
  input  logic [7:0]            data_byte,
  input  logic                  frame_end,
  output logic                  data_stall,
  input  logic                  q_full,
  output logic                  q_wr,
  output pce_pkg::pce_item_t    q_item,
  output pce_pkg::pce_front_status_t status
);
  import pce_pkg::*;

  logic [TAIL_BITS-1:0] shreg;
  logic [TAIL_BITS-1:0] shreg_next;
  logic [2:0]           phase;
  logic [2:0]           phase_next;

  logic [2:0]           per;
  logic [2:0]           ph0;
  logic [HIST_W-1:0]    hist;
  logic [CHUNK_W-1:0]   raw;
  logic [VRAW_W-1:0]    vraw;
  logic [VRAW_W-1:0]    packed_bits;
  logic [VRAW_W-1:0]    dropped;
  logic [3:0]           drop;
  logic                 accept;

  assign data_stall = q_full;
  assign accept     = data_valid && !q_full;
  assign q_wr       = accept;

  // Encode and puncture one byte
  always_comb begin
    per  = pce_period(rate);
    ph0  = (phase >= per) ? 3'd0 : phase;
    hist = '0;
    hist[TAIL_BITS-1:0] = shreg;
    for (int i = 0; i < DATA_BITS; i++) begin
      hist[TAIL_BITS+i] = data_byte[DATA_BITS-1-i];
    end
    raw = '0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      if (i < DATA_BITS || frame_end) begin
        raw[2*i]   = ^(hist[i +: K] & GEN_A);
        raw[2*i+1] = ^(hist[i +: K] & GEN_B);
      end
    end
    // prepend the skipped phases as dummy pairs, then drop their kept bits
    vraw        = VRAW_W'(raw) << {ph0, 1'b0};
    packed_bits = pce_compact(rate, vraw);
    drop        = (ph0 == 3'd0) ? 4'd0 : {1'b0, ph0} + 4'd1;
    dropped     = packed_bits >> drop;
    for (int k = 0; k < CHUNK_W; k++) begin
      q_item.bits[CHUNK_W-1-k] = dropped[k];
    end
    q_item.count = pce_kept_count(rate, ph0, frame_end);
    q_item.last  = frame_end;
  end

  // Advance encoder state; a frame end clears it
  always_comb begin
    if (frame_end) begin
      shreg_next = '0;
      phase_next = 3'd0;
    end else begin
      shreg_next = hist[DATA_BITS+TAIL_BITS-1:DATA_BITS];
      phase_next = pce_next_phase(rate, ph0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shreg <= '0;
      phase <= 3'd0;
    end else if (accept) begin
      shreg <= shreg_next;
      phase <= phase_next;
    end
  end

  assign status.shreg = shreg;
  assign status.phase = phase;

endmodule

// ===== hw/rtl/pce_queue.sv =====
// Small FIFO of punctured chunks between the front and the back end.
module pce_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  pce_pkg::pce_item_t wr_item,
  output logic               full,
  input  logic               rd,
  output logic               rd_valid,
  output pce_pkg::pce_item_t rd_item
);
  import pce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  pce_item_t          entries [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [OCC_W-1:0]   occ;
  logic               do_wr;
  logic               do_rd;

  assign full     = (occ == OCC_W'(DEPTH));
  assign rd_valid = (occ != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;
  assign rd_item  = entries[rptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      occ  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        occ <= occ + 1'b1;
      end else if (do_rd && !do_wr) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/pce_back.sv =====
// Back end: packs kept bits into bytes, pads the frame tail and drives the output register.
module pce_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  pce_pkg::pce_item_t        q_item,
  output logic                      q_rd,
  output logic                      coded_valid,
  input  logic                      coded_stall,
  output logic [7:0]                coded_byte,
  output logic                      last_out,
  output pce_pkg::pce_back_status_t status
);
  import pce_pkg::*;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              pend_last;
  logic              pend_last_next;

  logic              can_out;
  logic              emit;
  logic              emit_last;
  logic [FILL_W-1:0] fill_ae;
  logic [ACC_W-1:0]  acc_ae;
  logic              pend_ae;
  logic              load;

  // Emit one byte, then merge the next chunk behind what is left
  always_comb begin
    can_out   = !coded_valid || !coded_stall;
    emit      = can_out && (fill >= FILL_W'(8) || (pend_last && fill != '0));
    emit_last = emit && pend_last && fill <= FILL_W'(8);
    if (emit) begin
      fill_ae = (fill >= FILL_W'(8)) ? fill - FILL_W'(8) : '0;
      acc_ae  = acc << 8;
    end else begin
      fill_ae = fill;
      acc_ae  = acc;
    end
    pend_ae = pend_last && !emit_last;
    load    = q_valid && fill_ae < FILL_W'(8) && !pend_ae;
    if (load) begin
      acc_next       = acc_ae | ({q_item.bits, {(ACC_W-CHUNK_W){1'b0}}} >> fill_ae);
      fill_next      = fill_ae + FILL_W'(q_item.count);
      pend_last_next = q_item.last;
    end else begin
      acc_next       = acc_ae;
      fill_next      = fill_ae;
      pend_last_next = pend_ae;
    end
  end

  assign q_rd = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fill      <= '0;
      pend_last <= 1'b0;
    end else begin
      acc       <= acc_next;
      fill      <= fill_next;
      pend_last <= pend_last_next;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      coded_valid <= 1'b0;
    end else if (can_out) begin
      coded_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coded_byte <= acc[ACC_W-1 -: 8];
      last_out   <= emit_last;
    end
  end

  assign status.fill      = fill;
  assign status.pend_last = pend_last;

endmodule

// ===== hw/rtl/punctured_convolutional_encoder.sv =====
// Top level of the 802.11 K=7 punctured convolutional encoder with its register port.
//
//   channel  signals                                   direction
//   data     data_valid, data_stall, data_byte, frame_end   in
//   coded    coded_valid, coded_stall, coded_byte, last_out out
//   regs     psel, penable, pwrite, paddr, pwdata, prdata  APB
//
// The front encodes and punctures a whole byte (plus tail on frame end) combinationally.
// The back packs one coded byte per cycle while the coded output is not stalled.
// Reset clears encoder state, queue, pack buffer and sets rate 1/2.
// A stall on coded backs up the queue, which then stalls data.
module punctured_convolutional_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        coded_valid,
  input  logic        coded_stall,
  output logic [7:0]  coded_byte,
  output logic        last_out
);
  import pce_pkg::*;

  localparam logic REG_RATE_SELECT = 1'b0;

  rate_t             rate_select;
  logic              q_wr;
  logic              q_full;
  logic              q_rd;
  logic              q_valid;
  pce_item_t         wr_item;
  pce_item_t         rd_item;
  pce_front_status_t front_status;
  pce_back_status_t  back_status;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RATE_SELECT) ? {30'd0, rate_select} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_select <= RATE_1_2;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RATE_SELECT) begin
      rate_select <= rate_t'(pwdata[1:0]);
    end
  end

  pce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rate       (rate_select),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .data_stall (data_stall),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_item     (wr_item),
    .status     (front_status)
  );

  pce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_item  (wr_item),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  pce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (rd_item),
    .q_rd        (q_rd),
    .coded_valid (coded_valid),
    .coded_stall (coded_stall),
    .coded_byte  (coded_byte),
    .last_out    (last_out),
    .status      (back_status)
  );

  // Pack buffer never holds more than a partial byte plus one full chunk
  assert property (@(posedge clk) disable iff (rst)
    back_status.fill <= FILL_W'(MAX_FILL))
    else $error("pack buffer overfilled");

  // A pending frame end always has bits left to flush
  assert property (@(posedge clk) disable iff (rst)
    back_status.pend_last |-> back_status.fill != '0)
    else $error("frame end pending with empty pack buffer");

  // An accepted frame end leaves the encoder in its start state
  assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && frame_end |=>
      front_status.shreg == '0 && front_status.phase == 3'd0)
    else $error("encoder state not cleared after frame end");

endmodule

// ===== tb/punctured_convolutional_encoder_checker.sv =====
// Checker for the punctured convolutional encoder: predicts coded bytes and compares them.
`timescale 1ns / 1ps

module punctured_convolutional_encoder_checker #(
  parameter logic [2:0] RATE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        data_valid,
  input  logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic        coded_valid,
  input  logic        coded_stall,
  input  logic [7:0]  coded_byte,
  input  logic        last_out,
  output int          fail_count,
  output int          pending
);
  import pce_pkg::*;

  typedef struct packed {
    logic [7:0] coded;
    logic       last;
  } coded_item_t;

  coded_item_t coded_q[$];

  // Predictor state
  rate_t      coded_rate;
  logic [5:0] enc_shift;
  logic [2:0] punct_phase;
  logic [7:0] pack_buf;
  logic [3:0] pack_cnt;

  function automatic logic [2:0] puncture_period(input rate_t r);
    case (r)
      RATE_1_2: return 3'd1;
      RATE_2_3: return 3'd2;
      RATE_3_4: return 3'd3;
      default:  return 3'd5;
    endcase
  endfunction

  // Keep patterns: A = 1, 11, 110, 11010 and B = 1, 10, 101, 10101
  function automatic logic keep_a(input rate_t r, input logic [2:0] ph);
    case (r)
      RATE_1_2, RATE_2_3: return 1'b1;
      RATE_3_4:           return ph != 3'd2;
      default:            return ph == 3'd0 || ph == 3'd1 || ph == 3'd3;
    endcase
  endfunction

  function automatic logic keep_b(input rate_t r, input logic [2:0] ph);
    case (r)
      RATE_1_2: return 1'b1;
      RATE_2_3: return ph == 3'd0;
      RATE_3_4: return ph != 3'd1;
      default:  return ph == 3'd0 || ph == 3'd2 || ph == 3'd4;
    endcase
  endfunction

  // Shift one kept bit into the pack buffer, queue a full byte
  task pack_coded_bit(input logic b);
    pack_buf = {pack_buf[6:0], b};
    pack_cnt = pack_cnt + 4'd1;
    if (pack_cnt == 4'd8) begin
      coded_q.push_back('{coded: pack_buf, last: 1'b0});
      pack_buf = '0;
      pack_cnt = '0;
    end
  endtask

  // Encode one bit and puncture both outputs by the current phase
  task encode_data_bit(input logic b);
    logic [6:0] window;
    if (punct_phase >= puncture_period(coded_rate)) punct_phase = 3'd0;
    window = {b, enc_shift};
    if (keep_a(coded_rate, punct_phase)) pack_coded_bit(^(window & GEN_A));
    if (keep_b(coded_rate, punct_phase)) pack_coded_bit(^(window & GEN_B));
    enc_shift = window[6:1];
    punct_phase = punct_phase + 3'd1;
    if (punct_phase >= puncture_period(coded_rate)) punct_phase = 3'd0;
  endtask

  // Work out the coded bytes caused by one data byte
  task predict_coded_bytes(input logic [7:0] d, input logic fe);
    coded_item_t final_item;
    for (int i = 7; i >= 0; i--) encode_data_bit(d[i]);
    if (fe) begin
      repeat (TAIL_BITS) encode_data_bit(1'b0);
      if (pack_cnt != 4'd0) begin
        coded_q.push_back('{coded: 8'(pack_buf << (4'd8 - pack_cnt)), last: 1'b1});
      end else begin
        // ends on a byte boundary: mark the last full byte
        final_item = coded_q.pop_back();
        final_item.last = 1'b1;
        coded_q.push_back(final_item);
      end
      enc_shift   = '0;
      punct_phase = '0;
      pack_buf    = '0;
      pack_cnt    = '0;
    end
  endtask

  always @(posedge clk) begin
    coded_item_t exp_item;
    if (rst) begin
      coded_q.delete();
      coded_rate  = RATE_1_2;
      enc_shift   = '0;
      punct_phase = '0;
      pack_buf    = '0;
      pack_cnt    = '0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready && paddr[2] == RATE_ADDR[2]) begin
        coded_rate = rate_t'(pwdata[1:0]);
      end
      // Compare each coded transaction with the oldest expectation
      if (coded_valid && !coded_stall) begin
        if (coded_q.size() == 0) begin
          $error("unexpected coded transaction: coded_byte %02h last_out %0b",
                 coded_byte, last_out);
          fail_count++;
        end else begin
          exp_item = coded_q.pop_front();
          if (coded_byte !== exp_item.coded) begin
            $error("coded_byte: expected %02h, actual %02h", exp_item.coded, coded_byte);
            fail_count++;
          end
          if (last_out !== exp_item.last) begin
            $error("last_out: expected %0b, actual %0b", exp_item.last, last_out);
            fail_count++;
          end
        end
      end
      // Predict on each data transaction
      if (data_valid && !data_stall) predict_coded_bytes(data_byte, frame_end);
    end
    pending = coded_q.size();
  end

endmodule

// ===== tb/punctured_convolutional_encoder_test.sv =====
// Top of the punctured convolutional encoder testbench: stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module punctured_convolutional_encoder_test;
  import pce_pkg::*;

  localparam logic [2:0] RATE_SELECT_ADDR = 3'd0;
  localparam int IDLE_PCT       = 28;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 40;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        data_valid;
  logic        data_stall;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic        coded_valid;
  logic        coded_stall;
  logic [7:0]  coded_byte;
  logic        last_out;

  int   fail_count;
  int   pending;
  int   send_pct;
  int   stall_pct;
  int   quiet_cycles;
  logic hold_req;
  logic hold_done;

  punctured_convolutional_encoder u_dut (.*);

  punctured_convolutional_encoder_checker #(
    .RATE_ADDR(RATE_SELECT_ADDR)
  ) u_checker (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Write the rate register: setup cycle, then access cycle
  task automatic write_rate(input rate_t r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RATE_SELECT_ADDR;
    pwdata  <= {30'd0, r};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one data transaction after a random gap, hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fe);
    while ($urandom_range(99) < send_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    frame_end  <= fe;
    @(posedge clk);
    while (data_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every expected byte, then let the block settle
  task automatic wait_idle();
    data_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    coded_stall = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        coded_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done   <= 1'b1;
        coded_stall <= ($urandom_range(99) < stall_pct);
      end else begin
        coded_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (coded_valid && !coded_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rate_t next_rate;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    data_valid = 1'b0;
    data_byte  = '0;
    frame_end  = 1'b0;
    hold_req   = 1'b0;
    send_pct   = 0;
    stall_pct  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, a two-byte frame and a single-byte frame at rate 1/2
    write_rate(RATE_1_2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    wait_idle();
    write_rate(RATE_2_3);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_idle();
    // three-byte frame at 3/4 ends exactly on a byte boundary
    write_rate(RATE_3_4);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_idle();
    // leave a 5/6 frame open at phase three
    write_rate(RATE_5_6);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    // rate change inside a frame, phase beyond the new period
    write_rate(RATE_2_3);
    send_byte(8'h96, 1'b0);
    wait_idle();
    write_rate(RATE_5_6);
    send_byte(8'h69, 1'b0);
    wait_idle();
    write_rate(RATE_3_4);
    send_byte(8'h00, 1'b0);
    wait_idle();
    write_rate(RATE_1_2);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Random phases: first one without idling, one with a long hold-off
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_pct  = (p == 0) ? 0 : IDLE_PCT;
      stall_pct = (p == 0) ? 0 : IDLE_PCT;
      if (p == 1) next_rate = RATE_1_2;
      else if (p == 2) next_rate = RATE_5_6;
      else next_rate = rate_t'($urandom_range(3));
      write_rate(next_rate);
      if (p == 3) hold_req <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
      end
      wait_idle();
    end

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pce_pkg.sv
hw/rtl/pce_front.sv
hw/rtl/pce_queue.sv
hw/rtl/pce_back.sv
hw/rtl/punctured_convolutional_encoder.sv
tb/punctured_convolutional_encoder_checker.sv
tb/punctured_convolutional_encoder_test.sv
